/* src/pr_pkg.sv */
`timescale 1ns / 1ps
package pr_pkg;

	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 8192;
	localparam int NODE_AW   = $clog2(MAX_NODES);
	localparam int EDGE_AW   = $clog2(MAX_EDGES);
	localparam int CNT_W     = EDGE_AW + 1;          // edge total and out-degree
	localparam int NC_W      = NODE_AW + 1;          // node count
	localparam int RANK_W    = 32;
	localparam int DAMP_W    = 16;
	localparam int ITER_W    = 16;
	localparam int DSUM_W    = RANK_W + NODE_AW;     // sum of ranks over all nodes
	localparam int NEXT_W    = RANK_W + EDGE_AW;     // accumulated shares of one node
	localparam int SUM_W     = NEXT_W + 1;
	localparam int TELE_W    = RANK_W + 1;
	localparam int DIV_W     = DSUM_W;
	localparam int DVS_W     = (CNT_W > NC_W) ? CNT_W : NC_W;
	localparam int MUL_W     = RANK_W + DAMP_W;
	localparam int EDGE_DW   = 2 * NODE_AW;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_EDGE  = 2'd1,
		OP_RUN   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_NODES = 2'd0,
		REG_DAMP  = 2'd1,
		REG_THR   = 2'd2,
		REG_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [NC_W-1:0]   nodes;   // clamped to 1..MAX_NODES
		logic [DAMP_W-1:0] damp;
		logic [RANK_W-1:0] thr;
		logic [ITER_W-1:0] limit;
	} pr_cfg_t;

endpackage

/* src/pr_ram.sv */
`timescale 1ns / 1ps
module pr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/pr_div.sv */
`timescale 1ns / 1ps
module pr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pr_pkg::DIV_W-1:0]  dividend,
	input  logic [pr_pkg::DVS_W-1:0]  divisor,
	output logic                      done,
	output logic [pr_pkg::DIV_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(pr_pkg::DIV_W + 1);

	logic                     busy_q;
	logic                     done_q;
	logic [STEP_W-1:0]        step_q;
	logic [pr_pkg::DVS_W-1:0] rem_q;
	logic [pr_pkg::DVS_W-1:0] dvs_q;
	logic [pr_pkg::DIV_W-1:0] quo_q;
	logic [pr_pkg::DVS_W:0]   trial;
	logic                     fits;

	always_comb begin
		trial = {rem_q, quo_q[pr_pkg::DIV_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(pr_pkg::DIV_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? pr_pkg::DVS_W'(trial - {1'b0, dvs_q})
			              : trial[pr_pkg::DVS_W-1:0];
			quo_q <= {quo_q[pr_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* src/pr_core.sv */
`timescale 1ns / 1ps
module pr_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pr_pkg::pr_cfg_t             cfg,
	input  logic                        start,
	input  logic [1:0]                  op,
	input  logic [9:0]                  src_node,
	input  logic [9:0]                  dst_node,
	output logic                        busy,
	output logic                        done,
	output logic [31:0]                 rank_value,
	output logic [15:0]                 iterations_done,
	output logic                        converged,
	output logic [1:0]                  status
);

	localparam int NS = 23;

	typedef enum logic [NS-1:0] {
		S_CLR   = NS'(1) << 0,
		S_IDLE  = NS'(1) << 1,
		S_DEG   = NS'(1) << 2,
		S_RRD   = NS'(1) << 3,
		S_IDIV  = NS'(1) << 4,
		S_TDIV  = NS'(1) << 5,
		S_IWR   = NS'(1) << 6,
		S_CHK   = NS'(1) << 7,
		S_ZRD   = NS'(1) << 8,
		S_ZACC  = NS'(1) << 9,
		S_DDIV  = NS'(1) << 10,
		S_DMUL  = NS'(1) << 11,
		S_EFET  = NS'(1) << 12,
		S_EDAT  = NS'(1) << 13,
		S_EOP   = NS'(1) << 14,
		S_EDIV  = NS'(1) << 15,
		S_EMUL  = NS'(1) << 16,
		S_EACC  = NS'(1) << 17,
		S_ENEXT = NS'(1) << 18,
		S_URD   = NS'(1) << 19,
		S_UCALC = NS'(1) << 20,
		S_UACC  = NS'(1) << 21,
		S_ITEND = NS'(1) << 22
	} state_t;

	state_t                         state_q;
	logic [pr_pkg::NODE_AW-1:0]     cnt_q;
	logic [pr_pkg::NODE_AW-1:0]     src_q;
	logic [pr_pkg::NODE_AW-1:0]     tgt_q;
	logic [pr_pkg::EDGE_AW-1:0]     ecnt_q;
	logic [pr_pkg::CNT_W-1:0]       etot_q;
	logic [pr_pkg::ITER_W-1:0]      it_q;
	logic [pr_pkg::DSUM_W-1:0]      dsum_q;
	logic [pr_pkg::DSUM_W-1:0]      diff_q;
	logic [pr_pkg::RANK_W-1:0]      init_q;
	logic [pr_pkg::TELE_W-1:0]      tele_q;
	logic [pr_pkg::RANK_W-1:0]      dangle_q;
	logic [pr_pkg::RANK_W-1:0]      share_q;
	logic [pr_pkg::RANK_W-1:0]      nv_q;
	logic [pr_pkg::ITER_W-1:0]      last_it_q;
	logic                           last_conv_q;
	logic [pr_pkg::RANK_W-1:0]      rank_q;
	logic [1:0]                     status_q;
	logic                           done_q;
	logic                           div_start_q;
	logic [pr_pkg::DIV_W-1:0]       div_dvd_q;
	logic [pr_pkg::DVS_W-1:0]       div_dvs_q;

	logic                           div_done;
	logic [pr_pkg::DIV_W-1:0]       div_quo;

	logic                           deg_we, deg_re;
	logic [pr_pkg::NODE_AW-1:0]     deg_waddr, deg_raddr;
	logic [pr_pkg::CNT_W-1:0]       deg_wdata, deg_rdata;
	logic                           rank_we, rank_re;
	logic [pr_pkg::NODE_AW-1:0]     rank_waddr, rank_raddr;
	logic [pr_pkg::RANK_W-1:0]      rank_wdata, rank_rdata;
	logic                           next_we, next_re;
	logic [pr_pkg::NODE_AW-1:0]     next_waddr, next_raddr;
	logic [pr_pkg::NEXT_W-1:0]      next_wdata, next_rdata;
	logic                           edge_we, edge_re;
	logic [pr_pkg::EDGE_DW-1:0]     edge_wdata, edge_rdata;

	logic                           accept;
	logic                           src_out, dst_out, full;
	logic [pr_pkg::NC_W-1:0]        last_node;
	logic                           cnt_last;
	logic [pr_pkg::NODE_AW-1:0]     e_src, e_tgt;
	logic                           e_skip;
	logic [pr_pkg::MUL_W-1:0]       prod;
	logic [pr_pkg::SUM_W-1:0]       nsum;
	logic [pr_pkg::RANK_W-1:0]      nv;
	logic [pr_pkg::RANK_W-1:0]      delta;

	always_comb begin
		accept    = start && (state_q == S_IDLE);
		src_out   = ({1'b0, src_node} >= cfg.nodes);
		dst_out   = ({1'b0, dst_node} >= cfg.nodes);
		full      = (etot_q == pr_pkg::CNT_W'(pr_pkg::MAX_EDGES));
		last_node = cfg.nodes - 1'b1;
		cnt_last  = ({1'b0, cnt_q} == last_node);
		e_src     = edge_rdata[pr_pkg::EDGE_DW-1:pr_pkg::NODE_AW];
		e_tgt     = edge_rdata[pr_pkg::NODE_AW-1:0];
		e_skip    = ({1'b0, e_src} >= cfg.nodes) || ({1'b0, e_tgt} >= cfg.nodes);
		prod      = {{pr_pkg::DAMP_W{1'b0}}, div_quo[pr_pkg::RANK_W-1:0]}
		          * {{pr_pkg::RANK_W{1'b0}}, cfg.damp};
		nsum      = pr_pkg::SUM_W'(next_rdata) + pr_pkg::SUM_W'(tele_q)
		          + pr_pkg::SUM_W'(dangle_q);
		nv        = (|nsum[pr_pkg::SUM_W-1:pr_pkg::RANK_W]) ? '1
		          : nsum[pr_pkg::RANK_W-1:0];
		delta     = (nv_q >= rank_rdata) ? nv_q - rank_rdata : rank_rdata - nv_q;
	end

	// memory port steering
	always_comb begin
		deg_we     = 1'b0;
		deg_waddr  = cnt_q;
		deg_wdata  = '0;
		deg_re     = 1'b0;
		deg_raddr  = cnt_q;
		rank_we    = 1'b0;
		rank_waddr = cnt_q;
		rank_wdata = init_q;
		rank_re    = 1'b0;
		rank_raddr = cnt_q;
		next_we    = 1'b0;
		next_waddr = cnt_q;
		next_wdata = '0;
		next_re    = 1'b0;
		next_raddr = cnt_q;
		edge_we    = 1'b0;
		edge_wdata = {src_node, dst_node};
		edge_re    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				deg_we = 1'b1;
			end
			S_IDLE: begin
				if (accept && (op == pr_pkg::OP_EDGE) && !src_out && !dst_out && !full) begin
					deg_re    = 1'b1;
					deg_raddr = src_node;
					edge_we   = 1'b1;
				end
				if (accept && (op == pr_pkg::OP_READ)) begin
					rank_re    = 1'b1;
					rank_raddr = src_node;
				end
			end
			S_DEG: begin
				deg_we    = 1'b1;
				deg_waddr = src_q;
				deg_wdata = deg_rdata + 1'b1;
			end
			S_IWR: begin
				rank_we = 1'b1;
			end
			S_ZRD: begin
				deg_re  = 1'b1;
				rank_re = 1'b1;
				next_we = 1'b1;
			end
			S_EFET: begin
				edge_re = 1'b1;
			end
			S_EDAT: begin
				if (!e_skip) begin
					deg_re     = 1'b1;
					deg_raddr  = e_src;
					rank_re    = 1'b1;
					rank_raddr = e_src;
					next_re    = 1'b1;
					next_raddr = e_tgt;
				end
			end
			S_EACC: begin
				next_we    = 1'b1;
				next_waddr = tgt_q;
				next_wdata = next_rdata + pr_pkg::NEXT_W'(share_q);
			end
			S_URD: begin
				next_re = 1'b1;
				rank_re = 1'b1;
			end
			S_UACC: begin
				rank_we    = 1'b1;
				rank_wdata = nv_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			etot_q      <= '0;
			it_q        <= '0;
			last_it_q   <= '0;
			last_conv_q <= 1'b0;
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == pr_pkg::NODE_AW'(pr_pkg::MAX_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rank_q   <= '0;
						status_q <= pr_pkg::ST_OK;
						src_q    <= src_node;
						unique case (pr_pkg::op_t'(op))
							pr_pkg::OP_CLEAR: begin
								done_q  <= 1'b1;
								etot_q  <= '0;
								cnt_q   <= '0;
								state_q <= S_CLR;
							end
							pr_pkg::OP_EDGE: begin
								if (src_out || dst_out) begin
									status_q <= pr_pkg::ST_RANGE;
									done_q   <= 1'b1;
								end else if (full) begin
									status_q <= pr_pkg::ST_FULL;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_DEG;
								end
							end
							pr_pkg::OP_RUN: begin
								div_start_q <= 1'b1;
								div_dvd_q   <= pr_pkg::DIV_W'(1) << pr_pkg::RANK_W;
								div_dvs_q   <= pr_pkg::DVS_W'(cfg.nodes);
								state_q     <= S_IDIV;
							end
							pr_pkg::OP_READ: begin
								if (src_out) begin
									status_q <= pr_pkg::ST_RANGE;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_RRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DEG: begin
					etot_q  <= etot_q + 1'b1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RRD: begin
					rank_q  <= rank_rdata;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_IDIV: begin
					if (div_done) begin
						init_q      <= (|div_quo[pr_pkg::DIV_W-1:pr_pkg::RANK_W]) ? '1
						             : div_quo[pr_pkg::RANK_W-1:0];
						div_start_q <= 1'b1;
						div_dvd_q   <= (pr_pkg::DIV_W'(1) << pr_pkg::DAMP_W)
						             - pr_pkg::DIV_W'(cfg.damp) << pr_pkg::DAMP_W;
						state_q     <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						tele_q  <= div_quo[pr_pkg::TELE_W-1:0];
						cnt_q   <= '0;
						state_q <= S_IWR;
					end
				end
				S_IWR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						it_q    <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (it_q < cfg.limit) begin
						cnt_q   <= '0;
						dsum_q  <= '0;
						state_q <= S_ZRD;
					end else begin
						last_it_q   <= it_q;
						last_conv_q <= 1'b0;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_ZRD: begin
					state_q <= S_ZACC;
				end
				S_ZACC: begin
					if (deg_rdata == '0) begin
						dsum_q <= dsum_q + pr_pkg::DSUM_W'(rank_rdata);
					end
					if (cnt_last) begin
						div_start_q <= 1'b1;
						div_dvd_q   <= (deg_rdata == '0)
						             ? dsum_q + pr_pkg::DSUM_W'(rank_rdata) : dsum_q;
						div_dvs_q   <= pr_pkg::DVS_W'(cfg.nodes);
						state_q     <= S_DDIV;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_ZRD;
					end
				end
				S_DDIV: begin
					if (div_done) begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: begin
					dangle_q <= prod[pr_pkg::MUL_W-1:pr_pkg::DAMP_W];
					ecnt_q   <= '0;
					cnt_q    <= '0;
					diff_q   <= '0;
					state_q  <= (etot_q == '0) ? S_URD : S_EFET;
				end
				S_EFET: begin
					state_q <= S_EDAT;
				end
				S_EDAT: begin
					tgt_q   <= e_tgt;
					state_q <= e_skip ? S_ENEXT : S_EOP;
				end
				S_EOP: begin
					if (deg_rdata == '0) begin
						state_q <= S_ENEXT;
					end else begin
						div_start_q <= 1'b1;
						div_dvd_q   <= pr_pkg::DIV_W'(rank_rdata);
						div_dvs_q   <= pr_pkg::DVS_W'(deg_rdata);
						state_q     <= S_EDIV;
					end
				end
				S_EDIV: begin
					if (div_done) begin
						state_q <= S_EMUL;
					end
				end
				S_EMUL: begin
					share_q <= prod[pr_pkg::MUL_W-1:pr_pkg::DAMP_W];
					state_q <= S_EACC;
				end
				S_EACC: begin
					state_q <= S_ENEXT;
				end
				S_ENEXT: begin
					if (({1'b0, ecnt_q} + 1'b1) == etot_q) begin
						state_q <= S_URD;
					end else begin
						ecnt_q  <= ecnt_q + 1'b1;
						state_q <= S_EFET;
					end
				end
				S_URD: begin
					state_q <= S_UCALC;
				end
				S_UCALC: begin
					nv_q    <= nv;
					state_q <= S_UACC;
				end
				S_UACC: begin
					diff_q <= diff_q + pr_pkg::DSUM_W'(delta);
					if (cnt_last) begin
						state_q <= S_ITEND;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_URD;
					end
				end
				S_ITEND: begin
					it_q <= it_q + 1'b1;
					if (diff_q < pr_pkg::DSUM_W'(cfg.thr)) begin
						last_it_q   <= it_q + 1'b1;
						last_conv_q <= 1'b1;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_CHK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	pr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	pr_ram #(.WIDTH(pr_pkg::CNT_W), .DEPTH(pr_pkg::MAX_NODES)) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.re    (deg_re),
		.raddr (deg_raddr),
		.rdata (deg_rdata)
	);

	pr_ram #(.WIDTH(pr_pkg::RANK_W), .DEPTH(pr_pkg::MAX_NODES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (rank_wdata),
		.re    (rank_re),
		.raddr (rank_raddr),
		.rdata (rank_rdata)
	);

	pr_ram #(.WIDTH(pr_pkg::NEXT_W), .DEPTH(pr_pkg::MAX_NODES)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (next_re),
		.raddr (next_raddr),
		.rdata (next_rdata)
	);

	pr_ram #(.WIDTH(pr_pkg::EDGE_DW), .DEPTH(pr_pkg::MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (etot_q[pr_pkg::EDGE_AW-1:0]),
		.wdata (edge_wdata),
		.re    (edge_re),
		.raddr (ecnt_q),
		.rdata (edge_rdata)
	);

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign rank_value      = rank_q;
	assign iterations_done = last_it_q;
	assign converged       = last_conv_q;
	assign status          = status_q;

endmodule

/* src/pagerank_power_iteration.sv */
`timescale 1ns / 1ps
// Channel   Direction  Signals                                  Transaction when
// config    in/out     psel penable pwrite paddr pwdata prdata  psel & penable & pready
// command   in         start op src_node dst_node               start & !busy
// result    out        done rank_value iterations_done          done (one cycle)
//                      converged status
//
// Clear graph: result on the next cycle, then the out-degree memory is cleared (busy).
// Add edge and read rank: an error status answers from IDLE, else via S_DEG or S_RRD.
// Run: time grows with nodes, edges and iterations; the divider run on each edge
// dominates. After reset the out-degree memory is cleared (busy).
// Results cannot be stalled; one command is in flight at a time.
module pagerank_power_iteration (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pr_pkg::ADDR_W-1:0]   paddr,
	input  logic [pr_pkg::DATA_W-1:0]   pwdata,
	output logic [pr_pkg::DATA_W-1:0]   prdata,
	output logic                        pready,
	input  logic                        start,
	input  logic [1:0]                  op,
	input  logic [9:0]                  src_node,
	input  logic [9:0]                  dst_node,
	output logic                        busy,
	output logic                        done,
	output logic [31:0]                 rank_value,
	output logic [15:0]                 iterations_done,
	output logic                        converged,
	output logic [1:0]                  status
);

	logic [pr_pkg::NC_W-1:0]   nodes_q;
	logic [pr_pkg::DAMP_W-1:0] damp_q;
	logic [pr_pkg::RANK_W-1:0] thr_q;
	logic [pr_pkg::ITER_W-1:0] limit_q;
	pr_pkg::pr_cfg_t           cfg;
	pr_pkg::reg_idx_t          reg_idx;

	assign reg_idx = pr_pkg::reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= pr_pkg::NC_W'(1);
			damp_q  <= pr_pkg::DAMP_W'(55706);
			thr_q   <= pr_pkg::RANK_W'(4295);
			limit_q <= pr_pkg::ITER_W'(100);
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				pr_pkg::REG_NODES: nodes_q <= pwdata[pr_pkg::NC_W-1:0];
				pr_pkg::REG_DAMP:  damp_q  <= pwdata[pr_pkg::DAMP_W-1:0];
				pr_pkg::REG_THR:   thr_q   <= pwdata[pr_pkg::RANK_W-1:0];
				pr_pkg::REG_LIMIT: limit_q <= pwdata[pr_pkg::ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pr_pkg::REG_NODES: prdata = pr_pkg::DATA_W'(nodes_q);
			pr_pkg::REG_DAMP:  prdata = pr_pkg::DATA_W'(damp_q);
			pr_pkg::REG_THR:   prdata = pr_pkg::DATA_W'(thr_q);
			pr_pkg::REG_LIMIT: prdata = pr_pkg::DATA_W'(limit_q);
			default:           prdata = '0;
		endcase
	end

	// clamp node count into 1..MAX_NODES
	always_comb begin
		if (nodes_q == '0) begin
			cfg.nodes = pr_pkg::NC_W'(1);
		end else if (nodes_q > pr_pkg::NC_W'(pr_pkg::MAX_NODES)) begin
			cfg.nodes = pr_pkg::NC_W'(pr_pkg::MAX_NODES);
		end else begin
			cfg.nodes = nodes_q;
		end
		cfg.damp  = damp_q;
		cfg.thr   = thr_q;
		cfg.limit = limit_q;
	end

	pr_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.start           (start),
		.op              (op),
		.src_node        (src_node),
		.dst_node        (dst_node),
		.busy            (busy),
		.done            (done),
		.rank_value      (rank_value),
		.iterations_done (iterations_done),
		.converged       (converged),
		.status          (status)
	);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither answered nor in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == pr_pkg::ST_OK) || (status == pr_pkg::ST_FULL)
		      || (status == pr_pkg::ST_RANGE))
		else $error("undefined status code");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != pr_pkg::ST_OK) |-> rank_value == '0)
		else $error("rank returned with error status");

	a_conv_iter: assert property (@(posedge clk) disable iff (!arst_n)
		done && converged |-> iterations_done != '0)
		else $error("converged without any iteration");

endmodule
